FILE: rtl/s5scan_pkg.sv
// Shared types and AML constants for the S5 sleep type scanner.
`default_nettype none
package s5scan_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [2:0] sleep_type_a;
    logic [2:0] sleep_type_b;
  } out_t;

  localparam logic [7:0] NAME_OP    = 8'h08;
  localparam logic [7:0] PACKAGE_OP = 8'h12;
  localparam logic [7:0] INT_ZERO   = 8'h00;
  localparam logic [7:0] INT_ONE    = 8'h01;
  localparam logic [7:0] INT_BYTE   = 8'h0A;
  localparam logic [7:0] INT_WORD   = 8'h0B;
  localparam logic [7:0] INT_DWORD  = 8'h0C;
  localparam logic [7:0] MAX_SLP    = 8'h07;
  localparam logic [7:0] MIN_COUNT  = 8'h02;

  localparam logic [7:0] NAME_C0 = 8'h5F;
  localparam logic [7:0] NAME_C1 = 8'h53;
  localparam logic [7:0] NAME_C2 = 8'h35;
  localparam logic [7:0] NAME_C3 = 8'h5F;

  localparam int NAME_SPAN = 5;

endpackage
`default_nettype wire

FILE: rtl/s5scan_fifo.sv
// Two-entry request queue between the front and back parts.
`default_nettype none
module s5scan_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("request queue underflow");

endmodule
`default_nettype wire

FILE: rtl/s5scan_front.sv
// Front part: byte window, name match and end-of-table sweep.
`default_nettype none
module s5scan_front #(
  parameter int W = 32,
  localparam int CW = $clog2(W + 1),
  localparam int RW = $clog2(W),
  localparam int EW = 1 + RW + (W - 5) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire s5scan_pkg::in_t    req,
  output logic                    full,
  output logic                    q_wr,
  output logic [EW-1:0]           q_data,
  input  wire logic               q_full
);
  import s5scan_pkg::*;

  logic [7:0]    win     [W];
  logic [7:0]    win_new [W];
  logic [7:0]    src     [W];
  logic [CW-1:0] cnt;
  logic [CW-1:0] lim;
  logic          flushing;
  logic          accept;
  logic          acc_full;
  logic          q_end;
  logic [RW-1:0] q_rem;
  logic [(W-5)*8-1:0] q_bytes;

  function automatic logic name_hit(input logic [7:0] t0, input logic [7:0] t1,
                                    input logic [7:0] t2, input logic [7:0] t3,
                                    input logic [7:0] t4);
    name_hit = t0 == NAME_OP && t1 == NAME_C0 && t2 == NAME_C1 &&
               t3 == NAME_C2 && t4 == NAME_C3;
  endfunction

  assign full     = flushing | q_full;
  assign accept   = push && !full;
  assign acc_full = cnt >= CW'(W - 1);

  always_comb begin
    for (int k = 0; k < W - 1; k++) begin
      if (cnt == CW'(W)) begin
        win_new[k] = win[k+1];
      end else if (cnt == CW'(k)) begin
        win_new[k] = req.data_byte;
      end else begin
        win_new[k] = win[k];
      end
    end
    if (cnt == CW'(W) || cnt == CW'(W - 1)) begin
      win_new[W-1] = req.data_byte;
    end else begin
      win_new[W-1] = win[W-1];
    end
  end

  always_comb begin
    for (int k = 0; k < W; k++) begin
      src[k] = flushing ? win[k] : win_new[k];
    end
    for (int k = 5; k < W; k++) begin
      q_bytes[(k-5)*8 +: 8] = src[k];
    end
    q_wr  = 1'b0;
    q_end = 1'b0;
    q_rem = RW'(W - 5);
    if (accept) begin
      q_wr = acc_full && name_hit(win_new[0], win_new[1], win_new[2], win_new[3],
                                  win_new[4]);
    end else if (flushing && !q_full) begin
      if (lim >= CW'(NAME_SPAN)) begin
        q_wr  = name_hit(win[0], win[1], win[2], win[3], win[4]);
        q_rem = RW'(lim - CW'(NAME_SPAN));
      end else begin
        q_wr  = 1'b1;
        q_end = 1'b1;
      end
    end
    q_data = {q_end, q_rem, q_bytes};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      lim      <= '0;
      flushing <= 1'b0;
    end else if (accept) begin
      if (req.last) begin
        flushing <= 1'b1;
        lim      <= acc_full ? CW'(W - 1) : cnt + CW'(1);
      end else begin
        cnt <= acc_full ? CW'(W) : cnt + CW'(1);
      end
    end else if (flushing && !q_full) begin
      if (lim >= CW'(NAME_SPAN)) begin
        lim <= lim - CW'(1);
      end else begin
        flushing <= 1'b0;
        cnt      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.last && acc_full) begin
        for (int k = 0; k < W - 1; k++) begin
          win[k] <= win_new[k+1];
        end
        win[W-1] <= win_new[W-1];
      end else begin
        for (int k = 0; k < W; k++) begin
          win[k] <= win_new[k];
        end
      end
    end else if (flushing && !q_full) begin
      for (int k = 0; k < W - 1; k++) begin
        win[k] <= win[k+1];
      end
    end
  end

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    flushing |-> full)
    else $error("input taken during sweep");

endmodule
`default_nettype wire

FILE: rtl/s5scan_back.sv
// Back part: sequential package parser and result register.
`default_nettype none
module s5scan_back #(
  parameter int W = 32,
  parameter int LIMIT = 8,
  localparam int RW = $clog2(W),
  localparam int EW = 1 + RW + (W - 5) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire logic [EW-1:0]   q_rdata,
  output logic                 q_rd,
  output s5scan_pkg::out_t     res,
  output logic                 empty,
  input  wire logic            pop
);
  import s5scan_pkg::*;

  localparam int SW = $clog2(LIMIT + 1);
  localparam int NB = W - 5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_SKIP, ST_SCAN, ST_COUNT, ST_INT, ST_PAY
  } state_t;

  state_t        state;
  logic [7:0]    sr [NB];
  logic [RW-1:0] rem;
  logic [2:0]    skip_n;
  logic [SW-1:0] scan_n;
  logic          phase2;
  logic [2:0]    va;
  logic [2:0]    pay_val;
  logic          pay_ok;
  logic          pay_first;
  logic          hit;
  logic [2:0]    ha;
  logic [2:0]    hb;
  logic          out_valid;
  out_t          out_reg;

  logic          q_end;
  logic [RW-1:0] q_rem;
  logic [7:0]    cur;
  logic [1:0]    extra;
  logic [2:0]    nb;
  logic          ok_now;
  logic [2:0]    vbits;
  state_t        len_next;

  assign q_end = q_rdata[EW-1];
  assign q_rem = q_rdata[EW-2 -: RW];
  assign cur   = sr[0];
  assign extra = cur[7:6];
  assign res   = out_reg;
  assign empty = !out_valid;
  assign q_rd  = state == ST_IDLE && !q_empty && (!q_end || !out_valid);

  always_comb begin
    case (cur)
      INT_BYTE: nb = 3'd1;
      INT_WORD: nb = 3'd2;
      default:  nb = 3'd4;
    endcase
    ok_now   = pay_ok && (pay_first ? cur <= MAX_SLP : cur == 8'h00);
    vbits    = pay_first ? cur[2:0] : pay_val;
    len_next = phase2 ? ST_COUNT : ST_SCAN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (state != ST_IDLE) begin
        for (int k = 0; k < NB - 1; k++) begin
          sr[k] <= sr[k+1];
        end
        rem <= rem - RW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (q_rd) begin
            if (q_end) begin
              out_reg.found        <= hit;
              out_reg.sleep_type_a <= hit ? ha : 3'd0;
              out_reg.sleep_type_b <= hit ? hb : 3'd0;
              out_valid            <= 1'b1;
              hit                  <= 1'b0;
            end else if (!hit) begin
              for (int k = 0; k < NB; k++) begin
                sr[k] <= q_rdata[k*8 +: 8];
              end
              rem    <= q_rem;
              phase2 <= 1'b0;
              scan_n <= '0;
              state  <= ST_LEN;
            end
          end
        end
        ST_LEN: begin
          if (rem == '0 || rem < RW'(extra) + RW'(1)) begin
            state <= ST_IDLE;
          end else if (extra == 2'd0) begin
            scan_n <= '0;
            state  <= len_next;
          end else begin
            skip_n <= {1'b0, extra};
            state  <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          skip_n <= skip_n - 3'd1;
          if (skip_n == 3'd1) begin
            scan_n <= '0;
            state  <= len_next;
          end
        end
        ST_SCAN: begin
          if (scan_n == SW'(LIMIT) || rem == '0) begin
            state <= ST_IDLE;
          end else if (cur == PACKAGE_OP) begin
            phase2 <= 1'b1;
            state  <= ST_LEN;
          end else begin
            scan_n <= scan_n + SW'(1);
          end
        end
        ST_COUNT: begin
          if (rem == '0 || cur < MIN_COUNT) begin
            state <= ST_IDLE;
          end else begin
            phase2 <= 1'b0;
            state  <= ST_INT;
          end
        end
        ST_INT: begin
          if (rem == '0) begin
            state <= ST_IDLE;
          end else if (cur == INT_ZERO || cur == INT_ONE) begin
            if (!phase2) begin
              va     <= cur[2:0];
              phase2 <= 1'b1;
            end else begin
              hit   <= 1'b1;
              ha    <= va;
              hb    <= cur[2:0];
              state <= ST_IDLE;
            end
          end else if (cur == INT_BYTE || cur == INT_WORD || cur == INT_DWORD) begin
            if (rem < RW'(nb) + RW'(1)) begin
              state <= ST_IDLE;
            end else begin
              skip_n    <= nb;
              pay_ok    <= 1'b1;
              pay_first <= 1'b1;
              state     <= ST_PAY;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAY: begin
          pay_val   <= vbits;
          pay_ok    <= ok_now;
          pay_first <= 1'b0;
          skip_n    <= skip_n - 3'd1;
          if (skip_n == 3'd1) begin
            if (!ok_now) begin
              state <= ST_IDLE;
            end else if (!phase2) begin
              va     <= vbits;
              phase2 <= 1'b1;
              state  <= ST_INT;
            end else begin
              hit   <= 1'b1;
              ha    <= va;
              hb    <= vbits;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/acpi_s5_sleep_type_scanner_unit.sv
// Top level: S5 sleep type scanner over a streamed table.
// Throughput: one byte per cycle while full is low (full is raised during the end sweep and
// while the queue is full); a request is queued when an NameOp + _S5_ match reaches the window head.
// End of table: after the final byte the window is swept, one position per cycle unless
// the queue is full, then the result is registered when the parser takes the end marker.
// Reset: synchronous rst clears control, queue and the result valid flag; window bytes stay as they are.
`default_nettype none
module acpi_s5_sleep_type_scanner_unit #(
  parameter int WINDOW_BYTES = 32,
  parameter int PACKAGE_SCAN_LIMIT = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire s5scan_pkg::in_t  req,
  output logic                  empty,
  input  wire logic             pop,
  output s5scan_pkg::out_t      res
);
  import s5scan_pkg::*;

  localparam int RW = $clog2(WINDOW_BYTES);
  localparam int EW = 1 + RW + (WINDOW_BYTES - 5) * 8;

  logic          q_wr;
  logic [EW-1:0] q_wdata;
  logic          q_full;
  logic          q_rd;
  logic [EW-1:0] q_rdata;
  logic          q_empty;

  s5scan_front #(.W(WINDOW_BYTES)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .full   (full),
    .q_wr   (q_wr),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  s5scan_fifo #(.WIDTH(EW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  s5scan_back #(.W(WINDOW_BYTES), .LIMIT(PACKAGE_SCAN_LIMIT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_rd    (q_rd),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !res.found) |-> (res.sleep_type_a == 3'd0 && res.sleep_type_b == 3'd0))
    else $error("nonzero sleep type without a hit");

endmodule
`default_nettype wire
